// ===== design/rrts_pkg.sv =====
// rrts_pkg: shared types and constants of the round-robin time-slice scheduler
// request and result payloads, controller/datapath command and status groups
// no dependencies
package rrts_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 8;
  localparam int TIME_W          = 16;
  localparam int QUANT_W         = 16;
  localparam int QCNT_W          = 5;
  localparam int APB_DW          = 32;
  localparam int APB_AW          = 3;

  localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd50;
  localparam logic               REG_QUANTUM = 1'b0;

  typedef struct packed {
    logic              arrival_valid;
    logic [ID_W-1:0]   process_id;
    logic [TIME_W-1:0] exec_time;
  } in_t;

  typedef struct packed {
    logic              running_valid;
    logic [ID_W-1:0]   running_id;
    logic              completed_valid;
    logic [ID_W-1:0]   completed_id;
    logic              rotated;
    logic [QCNT_W-1:0] queue_count;
    logic              arrival_rejected;
  } out_t;

  typedef struct packed {
    logic accept;
    logic wr_pend;
    logic fetch;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic two_wr;
    logic need_load_now;
    logic need_load_r;
    logic out_free;
  } sts_t;

endpackage

// ===== design/round_robin_time_slice_scheduler.sv =====
// round_robin_time_slice_scheduler: top level, configuration register and wiring
// depends on rrts_pkg, rrts_ctrl, rrts_dpath
//
// channel   direction  handshake                 payload
// in        request    in_valid / in_stall       in_data (in_t): one time tick
// out       result     out_valid / out_stall     out_data (out_t): state after the tick
// cfg       write/read psel penable pwrite pready paddr, pwdata, prdata: quantum at 0
//
// a request passes through an evaluate step, a second queue write when a
// rotation and an arrival fall in the same tick, a read and a fetch of the new head
// from the queue memory after a retire or rotation, and the load of the result
// the result register frees the request side; a stalled result holds the next
// request in its last cycle. synchronous active-low reset, no memory clearing
module round_robin_time_slice_scheduler import rrts_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [QUANT_W-1:0] quantum_r, quantum_nxt;
  cmd_t               cmd;
  sts_t               sts;

  always_comb begin
    quantum_nxt = quantum_r;
    if (psel && penable && pwrite && (paddr[2] == REG_QUANTUM)) begin
      quantum_nxt = pwdata[QUANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
    end else begin
      quantum_r <= quantum_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANTUM) ? APB_DW'(quantum_r) : '0;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrts_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .quantum   (quantum_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== design/rrts_ram.sv =====
// rrts_ram: generic single write port memory with a registered read port
// no dependencies
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rrts_ctrl.sv =====
// rrts_ctrl: sequencing state machine of the scheduler
// depends on rrts_pkg for the command and status groups
module rrts_ctrl import rrts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WRITE  = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_FETCH  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.two_wr) begin
            state_nxt = ST_WRITE;
          end else if (sts.need_load_now) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_WRITE: begin
        cmd.wr_pend = 1'b1;
        state_nxt   = sts.need_load_r ? ST_READ : ST_FINISH;
      end
      ST_READ: begin
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== design/rrts_dpath.sv =====
// rrts_dpath: queue memory, head entry, counters, slice phase and result register
// depends on rrts_pkg and rrts_ram
module rrts_dpath import rrts_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  in_t                in_data,
  input  logic [QUANT_W-1:0] quantum,
  input  logic               out_stall,
  output logic               out_valid,
  output out_t               out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int ENT_W = ID_W + TIME_W;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] p, logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [QUANT_W-1:0] phase_r, phase_nxt;
  logic               started_r, started_nxt;
  logic [ID_W-1:0]    hd_id_r, hd_id_nxt;
  logic [TIME_W-1:0]  hd_rem_r, hd_rem_nxt;
  logic [PTR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic [ENT_W-1:0]   pend_ent_r, pend_ent_nxt;
  logic               need_load_r, need_load_nxt;
  logic               done_r, done_nxt;
  logic [ID_W-1:0]    done_id_r, done_id_nxt;
  logic               rot_r, rot_nxt;
  logic               rej_r, rej_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic               has;
  logic [TIME_W-1:0]  rem_dec;
  logic               done;
  logic [CNT_W-1:0]   count1;
  logic [PTR_W-1:0]   head1, head2;
  logic               rot;
  logic [PTR_W-1:0]   tail_rot, tail_arr;
  logic               arr_ok;
  logic [QUANT_W-1:0] q_eff, ph_base;
  logic [QUANT_W:0]   ph_inc;
  logic               need_load_now;
  logic [ENT_W-1:0]   arr_ent;

  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata, ram_rdata;

  assign has           = (count_r != '0);
  assign rem_dec       = hd_rem_r - TIME_W'(1);
  assign done          = has && (rem_dec == '0);
  assign count1        = count_r - CNT_W'(done);
  assign head1         = done ? ring_add(head_r, CNT_W'(1)) : head_r;
  assign rot           = !done && (phase_r == '0) && started_r && (count_r >= CNT_W'(2));
  assign head2         = rot ? ring_add(head1, CNT_W'(1)) : head1;
  assign tail_rot      = ring_add(head_r, count_r);
  assign tail_arr      = ring_add(head2, count1);
  assign arr_ok        = in_data.arrival_valid && (in_data.exec_time != '0) && (count1 < DEPTH_C);
  assign q_eff         = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign ph_base       = done ? '0 : phase_r;
  assign ph_inc        = (QUANT_W + 1)'(ph_base) + (QUANT_W + 1)'(1);
  assign need_load_now = (done || rot) && (count1 != '0);
  assign arr_ent       = {in_data.process_id, in_data.exec_time};

  // queue write: rotation copy or arrival at accept, deferred arrival afterwards
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_arr;
    ram_wdata = arr_ent;
    if (cmd.wr_pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_ent_r;
    end else if (cmd.accept && rot) begin
      ram_we    = 1'b1;
      ram_waddr = tail_rot;
      ram_wdata = {hd_id_r, rem_dec};
    end else if (cmd.accept && arr_ok) begin
      ram_we    = 1'b1;
    end
  end

  rrts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    started_nxt   = started_r;
    hd_id_nxt     = hd_id_r;
    hd_rem_nxt    = hd_rem_r;
    pend_addr_nxt = pend_addr_r;
    pend_ent_nxt  = pend_ent_r;
    need_load_nxt = need_load_r;
    done_nxt      = done_r;
    done_id_nxt   = done_id_r;
    rot_nxt       = rot_r;
    rej_nxt       = rej_r;
    if (cmd.accept) begin
      head_nxt      = head2;
      count_nxt     = count1 + CNT_W'(arr_ok);
      phase_nxt     = (ph_inc >= (QUANT_W + 1)'(q_eff)) ? '0 : ph_inc[QUANT_W-1:0];
      started_nxt   = 1'b1;
      pend_addr_nxt = tail_arr;
      pend_ent_nxt  = arr_ent;
      need_load_nxt = need_load_now;
      done_nxt      = done;
      done_id_nxt   = done ? hd_id_r : '0;
      rot_nxt       = rot;
      rej_nxt       = in_data.arrival_valid && !arr_ok;
      if (has && !done && !rot) begin
        hd_rem_nxt = rem_dec;
      end
      if ((count1 == '0) && arr_ok) begin
        hd_id_nxt  = in_data.process_id;
        hd_rem_nxt = in_data.exec_time;
      end
    end
    if (cmd.fetch) begin
      {hd_id_nxt, hd_rem_nxt} = ram_rdata;
    end
  end

  // result register, free again once the receiver takes it
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) begin
      out_valid_nxt            = 1'b1;
      out_nxt.running_valid    = has;
      out_nxt.running_id       = has ? hd_id_r : '0;
      out_nxt.completed_valid  = done_r;
      out_nxt.completed_id     = done_id_r;
      out_nxt.rotated          = rot_r;
      out_nxt.queue_count      = QCNT_W'(count_r);
      out_nxt.arrival_rejected = rej_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      phase_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hd_id_r     <= hd_id_nxt;
    hd_rem_r    <= hd_rem_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_ent_r  <= pend_ent_nxt;
    need_load_r <= need_load_nxt;
    done_r      <= done_nxt;
    done_id_r   <= done_id_nxt;
    rot_r       <= rot_nxt;
    rej_r       <= rej_nxt;
    out_r       <= out_nxt;
  end

  assign sts.two_wr        = rot && arr_ok;
  assign sts.need_load_now = need_load_now;
  assign sts.need_load_r   = need_load_r;
  assign sts.out_free      = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
